>>> hw/rtl/etac_pkg.sv
package etac_pkg;

  localparam int unsigned TimeWidthDef = 32;
  localparam int unsigned PeriodWidth  = 32;
  localparam int unsigned CountWidth   = 16;
  localparam int unsigned JobDepth     = 2;

  typedef enum logic [1:0] {
    BackIdle,
    BackDiv,
    BackDone
  } back_state_e;

endpackage

>>> hw/rtl/elapsed_time_alarm_counter_unit.sv
// An accepted item is written to the job queue; the back end then loads it, runs the divider on the
// run time and commits the result to the output registers, held until pop. The one-bit-per-cycle
// restoring divider takes one job at a time; a short job queue lets the front keep taking items.
// With a zero alarm period the divider is skipped and the job goes straight to commit.
// Reset (rst_ni low, asynchronous): timer not started, last time, alarm count and
// alarm period cleared, queues empty. No clearing pass is needed.
module elapsed_time_alarm_counter_unit import etac_pkg::*; #(
  parameter int unsigned TIME_WIDTH = TimeWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [PeriodWidth-1:0] alarm_period_us_i,
  input  logic                   push,
  output logic                   full,
  input  logic [TIME_WIDTH-1:0]  now_us_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [TIME_WIDTH-1:0]  delta_us_o,
  output logic [TIME_WIDTH-1:0]  run_us_o,
  output logic [CountWidth-1:0]  new_alarm_count_o
);

  logic                    job_push, job_full, job_pop, job_empty;
  logic [2*TIME_WIDTH-1:0] job_wdata, job_rdata;

  etac_front #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .now_us_i   (now_us_i),
    .cfg_we_i   (cfg_we_i),
    .job_full_i (job_full),
    .job_push_o (job_push),
    .job_data_o (job_wdata)
  );

  etac_job_queue #(
    .DATA_WIDTH (2 * TIME_WIDTH),
    .DEPTH      (JobDepth)
  ) u_job_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_wdata),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .data_o  (job_rdata)
  );

  etac_back #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .alarm_period_us_i (alarm_period_us_i),
    .job_empty_i       (job_empty),
    .job_data_i        (job_rdata),
    .job_pop_o         (job_pop),
    .empty             (empty),
    .pop               (pop),
    .delta_us_o        (delta_us_o),
    .run_us_o          (run_us_o),
    .new_alarm_count_o (new_alarm_count_o)
  );

endmodule

>>> hw/rtl/etac_front.sv
module etac_front import etac_pkg::*; #(
  parameter int unsigned TIME_WIDTH = TimeWidthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [TIME_WIDTH-1:0]     now_us_i,
  input  logic                      cfg_we_i,
  input  logic                      job_full_i,
  output logic                      job_push_o,
  output logic [2*TIME_WIDTH-1:0]   job_data_o
);

  logic [TIME_WIDTH-1:0] start_q, start_d;
  logic [TIME_WIDTH-1:0] last_q, last_d;
  logic [TIME_WIDTH-1:0] start_eff, last_eff;
  logic                  first_sample;
  logic                  accept;

  assign full   = job_full_i;
  assign accept = push && !job_full_i;

  // A zero start time marks the timer as not started: this sample starts it.
  assign first_sample = (start_q == '0);
  assign start_eff    = first_sample ? now_us_i : start_q;
  assign last_eff     = first_sample ? now_us_i : last_q;

  always_comb begin
    start_d = start_q;
    last_d  = last_q;
    if (cfg_we_i) begin
      start_d = '0;
    end else if (accept) begin
      start_d = start_eff;
      last_d  = now_us_i;
    end
  end

  assign job_push_o = accept;
  assign job_data_o = {now_us_i - last_eff, now_us_i - start_eff};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      last_q  <= '0;
    end else begin
      start_q <= start_d;
      last_q  <= last_d;
    end
  end

endmodule

>>> hw/rtl/etac_job_queue.sv
module etac_job_queue import etac_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 2 * TimeWidthDef,
  parameter int unsigned DEPTH      = JobDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [DATA_WIDTH-1:0] data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output logic [DATA_WIDTH-1:0] data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0] slot_q [DEPTH];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

>>> hw/rtl/etac_back.sv
module etac_back import etac_pkg::*; #(
  parameter int unsigned TIME_WIDTH = TimeWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [PeriodWidth-1:0]  alarm_period_us_i,
  input  logic                    job_empty_i,
  input  logic [2*TIME_WIDTH-1:0] job_data_i,
  output logic                    job_pop_o,
  output logic                    empty,
  input  logic                    pop,
  output logic [TIME_WIDTH-1:0]   delta_us_o,
  output logic [TIME_WIDTH-1:0]   run_us_o,
  output logic [CountWidth-1:0]   new_alarm_count_o
);

  localparam int unsigned CntW = (TIME_WIDTH > 1) ? $clog2(TIME_WIDTH) : 1;

  back_state_e state_q, state_d;

  logic [PeriodWidth-1:0] period_q;
  logic [CountWidth-1:0]  alarm_cnt_q, alarm_cnt_d;

  logic [TIME_WIDTH-1:0]  delta_q, run_q, dvd_q;
  logic [PeriodWidth-1:0] rem_q;
  logic [CountWidth-1:0]  quo_q;
  logic                   ovf_q;
  logic [CntW-1:0]        step_q;

  logic                   out_valid_q, out_valid_d;
  logic [TIME_WIDTH-1:0]  out_delta_q, out_run_q;
  logic [CountWidth-1:0]  out_report_q, report;

  logic                   load, div_step, commit, last_step, out_free;
  logic [PeriodWidth:0]   trial;
  logic                   trial_ge;
  logic [CountWidth-1:0]  sat_quo;

  assign out_free  = !out_valid_q || pop;
  assign last_step = (step_q == '0);

  // One quotient bit per cycle, restoring.
  assign trial    = {rem_q, dvd_q[TIME_WIDTH-1]};
  assign trial_ge = (trial >= {1'b0, period_q});
  assign sat_quo  = ovf_q ? {CountWidth{1'b1}} : quo_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BackIdle: begin
        if (!job_empty_i) begin
          // Skip the divider while alarms are disabled.
          state_d = (period_q == '0) ? BackDone : BackDiv;
        end
      end
      BackDiv: begin
        if (last_step) begin
          state_d = BackDone;
        end
      end
      BackDone: begin
        if (out_free) begin
          state_d = BackIdle;
        end
      end
      default: state_d = BackIdle;
    endcase
  end

  always_comb begin
    load     = 1'b0;
    div_step = 1'b0;
    commit   = 1'b0;
    case (state_q)
      BackIdle: load     = !job_empty_i;
      BackDiv:  div_step = 1'b1;
      BackDone: commit   = out_free;
      default: ;
    endcase
  end

  assign job_pop_o = load;

  always_comb begin
    alarm_cnt_d = alarm_cnt_q;
    report      = '0;
    if (period_q != '0 && alarm_cnt_q < sat_quo) begin
      alarm_cnt_d = sat_quo;
      report      = sat_quo;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = 1'b0;
    end
    if (commit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      run_q   <= job_data_i[TIME_WIDTH-1:0];
      delta_q <= job_data_i[2*TIME_WIDTH-1:TIME_WIDTH];
      dvd_q   <= job_data_i[TIME_WIDTH-1:0];
      rem_q   <= '0;
      quo_q   <= '0;
      ovf_q   <= 1'b0;
      step_q  <= CntW'(TIME_WIDTH - 1);
    end else if (div_step) begin
      dvd_q  <= dvd_q << 1;
      rem_q  <= trial_ge ? PeriodWidth'(trial - {1'b0, period_q}) : trial[PeriodWidth-1:0];
      // Any bit shifted past the top of the count saturates the quotient.
      ovf_q  <= ovf_q | quo_q[CountWidth-1];
      quo_q  <= {quo_q[CountWidth-2:0], trial_ge};
      step_q <= step_q - 1'b1;
    end
    if (commit) begin
      out_delta_q  <= delta_q;
      out_run_q    <= run_q;
      out_report_q <= report;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BackIdle;
      period_q    <= '0;
      alarm_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        period_q    <= alarm_period_us_i;
        alarm_cnt_q <= '0;
      end else if (commit) begin
        alarm_cnt_q <= alarm_cnt_d;
      end
    end
  end

  assign empty             = !out_valid_q;
  assign delta_us_o        = out_delta_q;
  assign run_us_o          = out_run_q;
  assign new_alarm_count_o = out_report_q;

endmodule
